@@ sv/vrc_pkg.sv @@
`default_nettype none
package vrc_pkg;

  localparam int ACT_W      = 2;
  localparam int TILE_W     = 6;
  localparam int BYTE_W     = 8;
  localparam int COLOUR_W   = 3 * BYTE_W;
  localparam int PIX_W      = 10;
  localparam int SCALE_W    = 24;
  localparam int Q_W        = PIX_W + SCALE_W - 8 + 1;
  localparam int SITE_W     = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_NUM_TILES = 64;
  localparam int DEF_MAX_DIM   = 1024;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PIXEL  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd16384;

  localparam logic signed [SITE_W-1:0] Q_MIN = -18'sd131072;
  localparam logic signed [SITE_W-1:0] Q_MAX = 18'sd131071;

  // Adds the signed offset to the rounded mean and clamps to Q2.16.
  function automatic logic signed [SITE_W-1:0] sat_q(input logic [Q_W-1:0] q,
                                                    input logic signed [SITE_W-1:0] off);
    logic signed [Q_W+1:0] v;
    v = $signed({2'b00, q}) + (Q_W+2)'(off);
    if (v > (Q_W+2)'(Q_MAX)) begin
      sat_q = Q_MAX;
    end else if (v < (Q_W+2)'(Q_MIN)) begin
      sat_q = Q_MIN;
    end else begin
      sat_q = v[SITE_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/voronoi_region_centroid.sv @@
`default_nettype none
// Channel   Handshake              Word
// in        in_valid / in_stall    action, tile_index, colour_*, site_*, pixel_*
// out       out_valid / out_stall  region_index, centroid_x/y, was_empty, last
// cfg       cfg_we                 cfg_index, cfg_data
// A load is written to the tables in the cycle it is accepted. A pixel scans the colour
// memory one tile per cycle, then reads and writes its sums (S_ACC_RD, S_ACC_WR).
// A finish reads each tile's sums (S_F_RD, S_F_LD), runs the shared divider for x and then y
// unless the tile is empty (27 quotient bits), and holds each result while out_stall is high.
// Reset is synchronous; it clears the loaded and accumulator valid bits.
module voronoi_region_centroid #(
  parameter int NUM_TILES = vrc_pkg::DEF_NUM_TILES,
  parameter int MAX_DIM   = vrc_pkg::DEF_MAX_DIM
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [vrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vrc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [vrc_pkg::ACT_W-1:0]         action,
  input  wire logic [vrc_pkg::TILE_W-1:0]        tile_index,
  input  wire logic [vrc_pkg::BYTE_W-1:0]        colour_r,
  input  wire logic [vrc_pkg::BYTE_W-1:0]        colour_g,
  input  wire logic [vrc_pkg::BYTE_W-1:0]        colour_b,
  input  wire logic signed [vrc_pkg::SITE_W-1:0] site_x,
  input  wire logic signed [vrc_pkg::SITE_W-1:0] site_y,
  input  wire logic [vrc_pkg::PIX_W-1:0]         pixel_x,
  input  wire logic [vrc_pkg::PIX_W-1:0]         pixel_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [vrc_pkg::TILE_W-1:0]             region_index,
  output logic signed [vrc_pkg::SITE_W-1:0]      centroid_x,
  output logic signed [vrc_pkg::SITE_W-1:0]      centroid_y,
  output logic                                   was_empty,
  output logic                                   last
);

  localparam int    TI_W  = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
  localparam int    K_W   = $clog2(NUM_TILES + 1);
  localparam longint CAP  = longint'(MAX_DIM) * longint'(MAX_DIM);
  localparam int    CNT_W = $clog2(CAP + 1);
  localparam int    SUM_W = $clog2((longint'(2) ** vrc_pkg::PIX_W - 1) * CAP + 1);
  localparam int    ACC_W = CNT_W + 2 * SUM_W;
  localparam int    SW    = vrc_pkg::SITE_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_ACC_RD = 3'd2;
  localparam logic [2:0] S_ACC_WR = 3'd3;
  localparam logic [2:0] S_F_RD   = 3'd4;
  localparam logic [2:0] S_F_LD   = 3'd5;
  localparam logic [2:0] S_F_DIV  = 3'd6;
  localparam logic [2:0] S_F_OUT  = 3'd7;

  logic [2:0]                    state;
  logic [vrc_pkg::SCALE_W-1:0]   scale_x;
  logic [vrc_pkg::SCALE_W-1:0]   scale_y;
  logic signed [SW-1:0]          offset_x;
  logic signed [SW-1:0]          offset_y;

  logic [vrc_pkg::COLOUR_W-1:0]  colour_mem [NUM_TILES];
  logic [2*SW-1:0]               site_mem   [NUM_TILES];
  logic [ACC_W-1:0]              acc_mem    [NUM_TILES];
  logic [vrc_pkg::COLOUR_W-1:0]  colour_q;
  logic [2*SW-1:0]               site_q;
  logic [ACC_W-1:0]              acc_q;
  logic [NUM_TILES-1:0]          loaded;
  logic [NUM_TILES-1:0]          acc_ok;

  logic [K_W-1:0]                scan_k;
  logic [TI_W-1:0]               cmp_k;
  logic                          cmp_v;
  logic [TI_W-1:0]               hit_k;
  logic [TI_W-1:0]               fin_k;
  logic [vrc_pkg::COLOUR_W-1:0]  pix_col;
  logic [vrc_pkg::PIX_W-1:0]     pix_x;
  logic [vrc_pkg::PIX_W-1:0]     pix_y;
  logic [SUM_W-1:0]              sy_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          div_y;

  logic                          in_acc;
  logic                          tile_ok;
  logic                          load_we;
  logic [TI_W-1:0]               acc_raddr;
  logic [TI_W-1:0]               acc_idx;
  logic [ACC_W-1:0]              cur;
  logic [CNT_W-1:0]              cur_cnt;
  logic [SUM_W-1:0]              cur_sx;
  logic [SUM_W-1:0]              cur_sy;
  logic                          acc_we;
  logic                          div_start;
  logic [SUM_W-1:0]              div_sum;
  logic [vrc_pkg::SCALE_W-1:0]   div_scale;
  logic [CNT_W-1:0]              div_cnt;
  logic                          div_busy;
  logic                          div_done;
  logic [vrc_pkg::Q_W-1:0]       div_q;

  assign in_stall  = state != S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign tile_ok   = 32'(tile_index) < 32'(NUM_TILES);
  assign load_we   = in_acc && action == vrc_pkg::ACT_LOAD && tile_ok;
  assign acc_raddr = (state == S_ACC_RD) ? hit_k : fin_k;
  assign acc_idx   = (state == S_ACC_WR) ? hit_k : fin_k;
  assign cur       = acc_ok[acc_idx] ? acc_q : '0;
  assign cur_cnt   = cur[ACC_W-1 -: CNT_W];
  assign cur_sy    = cur[2*SUM_W-1 -: SUM_W];
  assign cur_sx    = cur[SUM_W-1:0];
  assign acc_we    = state == S_ACC_WR && 64'(cur_cnt) < 64'(CAP);
  assign div_start = (state == S_F_LD && cur_cnt != '0) ||
                     (state == S_F_DIV && div_done && !div_y);
  assign div_sum   = (state == S_F_LD) ? cur_sx : sy_r;
  assign div_scale = (state == S_F_LD) ? scale_x : scale_y;
  assign div_cnt   = (state == S_F_LD) ? cur_cnt : cnt_r;

  vrc_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .sum  (div_sum),
    .scale(div_scale),
    .count(div_cnt),
    .busy (div_busy),
    .done (div_done),
    .quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (load_we) begin
      colour_mem[tile_index[TI_W-1:0]] <= {colour_r, colour_g, colour_b};
      site_mem[tile_index[TI_W-1:0]]   <= {site_y, site_x};
    end
    if (acc_we) begin
      acc_mem[hit_k] <= {cur_cnt + 1'b1, cur_sy + SUM_W'(pix_y), cur_sx + SUM_W'(pix_x)};
    end
    colour_q <= colour_mem[scan_k[TI_W-1:0]];
    site_q   <= site_mem[fin_k];
    acc_q    <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x  <= vrc_pkg::SCALE_RESET;
      scale_y  <= vrc_pkg::SCALE_RESET;
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vrc_pkg::REG_SCALE_X:  scale_x  <= cfg_data;
        vrc_pkg::REG_SCALE_Y:  scale_y  <= cfg_data;
        vrc_pkg::REG_OFFSET_X: offset_x <= cfg_data[SW-1:0];
        vrc_pkg::REG_OFFSET_Y: offset_y <= cfg_data[SW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      loaded    <= '0;
      acc_ok    <= '0;
      cmp_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_v <= state == S_SCAN && 32'(scan_k) < 32'(NUM_TILES);
      if (load_we) begin
        loaded[tile_index[TI_W-1:0]] <= 1'b1;
      end
      if (acc_we) begin
        acc_ok[hit_k] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && action == vrc_pkg::ACT_PIXEL &&
              32'(pixel_x) < 32'(MAX_DIM) && 32'(pixel_y) < 32'(MAX_DIM)) begin
            state <= S_SCAN;
          end else if (in_acc && action == vrc_pkg::ACT_FINISH) begin
            state <= S_F_RD;
          end
        end
        S_SCAN: begin
          if (cmp_v && loaded[cmp_k] && colour_q == pix_col) begin
            state <= S_ACC_RD;
          end else if (cmp_v && cmp_k == TI_W'(NUM_TILES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_ACC_RD: begin
          state <= S_ACC_WR;
        end
        S_ACC_WR: begin
          state <= S_IDLE;
        end
        S_F_RD: begin
          state <= S_F_LD;
        end
        S_F_LD: begin
          if (cur_cnt == '0) begin
            state     <= S_F_OUT;
            out_valid <= 1'b1;
          end else begin
            state <= S_F_DIV;
          end
        end
        S_F_DIV: begin
          if (div_done && div_y) begin
            state     <= S_F_OUT;
            out_valid <= 1'b1;
          end
        end
        S_F_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last) begin
              acc_ok <= '0;
              state  <= S_IDLE;
            end else begin
              state <= S_F_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cmp_k <= scan_k[TI_W-1:0];
    case (state)
      S_IDLE: begin
        pix_col <= {colour_r, colour_g, colour_b};
        pix_x   <= pixel_x;
        pix_y   <= pixel_y;
        scan_k  <= '0;
        fin_k   <= '0;
      end
      S_SCAN: begin
        if (32'(scan_k) < 32'(NUM_TILES)) begin
          scan_k <= scan_k + 1'b1;
        end
        hit_k <= cmp_k;
      end
      S_F_LD: begin
        sy_r         <= cur_sy;
        cnt_r        <= cur_cnt;
        div_y        <= 1'b0;
        region_index <= vrc_pkg::TILE_W'(fin_k);
        last         <= fin_k == TI_W'(NUM_TILES - 1);
        was_empty    <= cur_cnt == '0;
        centroid_x   <= loaded[fin_k] ? site_q[SW-1:0] : '0;
        centroid_y   <= loaded[fin_k] ? site_q[2*SW-1:SW] : '0;
      end
      S_F_DIV: begin
        if (div_done && !div_y) begin
          centroid_x <= vrc_pkg::sat_q(div_q, offset_x);
          div_y      <= 1'b1;
        end else if (div_done) begin
          centroid_y <= vrc_pkg::sat_q(div_q, offset_y);
        end
      end
      S_F_OUT: begin
        if (!out_stall && !last) begin
          fin_k <= fin_k + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  a_no_accept_while_out : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while a result is pending");

  a_clear_after_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> acc_ok == '0 && state == S_IDLE)
    else $error("accumulators not cleared after the last result");

  a_div_start_idle : assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider started while busy");

  a_acc_in_pixel : assert property (@(posedge clk) disable iff (rst)
    acc_we |-> $past(state) == S_ACC_RD) else $error("accumulator written out of turn");

endmodule
`default_nettype wire

@@ sv/vrc_div.sv @@
`default_nettype none
module vrc_div #(
  parameter int SUM_W = 30,
  parameter int CNT_W = 21
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [SUM_W-1:0]             sum,
  input  wire logic [vrc_pkg::SCALE_W-1:0]  scale,
  input  wire logic [CNT_W-1:0]             count,
  output logic                              busy,
  output logic                              done,
  output logic [vrc_pkg::Q_W-1:0]           quot
);

  localparam int DEN_W  = CNT_W + 8;
  localparam int PROD_W = SUM_W + vrc_pkg::SCALE_W;
  localparam int DVD_W  = PROD_W + 1;
  localparam int STEP_W = $clog2(vrc_pkg::Q_W + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_ADD  = 2'd2;
  localparam logic [1:0] D_ITER = 2'd3;

  logic [1:0]                    dstate;
  logic [SUM_W-1:0]              op_sum;
  logic [vrc_pkg::SCALE_W-1:0]   op_scale;
  logic [CNT_W-1:0]              op_cnt;
  logic [PROD_W-1:0]             prod;
  logic [DEN_W-1:0]              den;
  logic [DEN_W-1:0]              rem;
  logic [vrc_pkg::Q_W-1:0]       low;
  logic [STEP_W-1:0]             step;
  logic [DVD_W-1:0]              dvd;
  logic [DEN_W:0]                trial;
  logic                          ge;

  assign dvd   = {1'b0, prod} + DVD_W'({op_cnt, 7'd0});
  assign trial = {rem, low[vrc_pkg::Q_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign busy  = dstate != D_IDLE;
  assign quot  = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (dstate)
        D_IDLE: begin
          if (start) begin
            dstate <= D_MUL;
          end
        end
        D_MUL: begin
          dstate <= D_ADD;
        end
        D_ADD: begin
          dstate <= D_ITER;
        end
        D_ITER: begin
          if (step == STEP_W'(vrc_pkg::Q_W - 1)) begin
            dstate <= D_IDLE;
            done   <= 1'b1;
          end
        end
        default: begin
          dstate <= D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dstate == D_IDLE && start) begin
      op_sum   <= sum;
      op_scale <= scale;
      op_cnt   <= count;
    end
    if (dstate == D_MUL) begin
      prod <= op_sum * op_scale;
      den  <= {op_cnt, 8'd0};
    end
    if (dstate == D_ADD) begin
      rem  <= DEN_W'(dvd >> vrc_pkg::Q_W);
      low  <= dvd[vrc_pkg::Q_W-1:0];
      step <= '0;
    end
    if (dstate == D_ITER) begin
      rem  <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      low  <= {low[vrc_pkg::Q_W-2:0], ge};
      step <= step + 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/voronoi_region_centroid_tb.sv @@
`timescale 1ns / 100ps
module voronoi_region_centroid_tb;

  localparam int NT = vrc_pkg::DEF_NUM_TILES;
  localparam int WATCH_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 600;
  localparam logic [vrc_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [vrc_pkg::ACT_W-1:0]         act;
    logic [vrc_pkg::TILE_W-1:0]        tile;
    logic [vrc_pkg::BYTE_W-1:0]        r;
    logic [vrc_pkg::BYTE_W-1:0]        g;
    logic [vrc_pkg::BYTE_W-1:0]        b;
    logic signed [vrc_pkg::SITE_W-1:0] sx;
    logic signed [vrc_pkg::SITE_W-1:0] sy;
    logic [vrc_pkg::PIX_W-1:0]         px;
    logic [vrc_pkg::PIX_W-1:0]         py;
  } word_t;

  typedef struct packed {
    logic [vrc_pkg::TILE_W-1:0]        idx;
    logic signed [vrc_pkg::SITE_W-1:0] cx;
    logic signed [vrc_pkg::SITE_W-1:0] cy;
    logic                              empty;
    logic                              lst;
  } centroid_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [vrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [vrc_pkg::ACT_W-1:0] action = '0;
  logic [vrc_pkg::TILE_W-1:0] tile_index = '0;
  logic [vrc_pkg::BYTE_W-1:0] colour_r = '0, colour_g = '0, colour_b = '0;
  logic signed [vrc_pkg::SITE_W-1:0] site_x = '0, site_y = '0;
  logic [vrc_pkg::PIX_W-1:0] pixel_x = '0, pixel_y = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [vrc_pkg::TILE_W-1:0] region_index;
  logic signed [vrc_pkg::SITE_W-1:0] centroid_x, centroid_y;
  logic was_empty, last;

  voronoi_region_centroid dut (.*);

  initial forever #2 clk = ~clk;

  // Predictor state.
  logic [vrc_pkg::SCALE_W-1:0] pscale_x = vrc_pkg::SCALE_RESET;
  logic [vrc_pkg::SCALE_W-1:0] pscale_y = vrc_pkg::SCALE_RESET;
  logic signed [vrc_pkg::SITE_W-1:0] poff_x = '0, poff_y = '0;
  logic [vrc_pkg::COLOUR_W-1:0] ptable [NT];
  logic [NT-1:0] ploaded = '0;
  logic signed [vrc_pkg::SITE_W-1:0] psite_x [NT], psite_y [NT];
  longint unsigned psum_x [NT], psum_y [NT], pcount [NT];

  word_t pending_words [$];
  centroid_t expected_centroids [$];
  word_t cur_word;
  int errors = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_req = 0, hold_started = 0;
  bit no_gaps = 0;
  logic [vrc_pkg::COLOUR_W-1:0] palette [8];

  initial begin
    for (int k = 0; k < NT; k++) begin
      ptable[k] = '0; psite_x[k] = '0; psite_y[k] = '0;
      psum_x[k] = 0; psum_y[k] = 0; pcount[k] = 0;
    end
  end

  function automatic logic signed [vrc_pkg::SITE_W-1:0] world_coord(longint unsigned sum,
      logic [vrc_pkg::SCALE_W-1:0] scale, longint unsigned cnt,
      logic signed [vrc_pkg::SITE_W-1:0] off);
    longint unsigned num, den;
    longint v;
    num = sum * scale;
    den = cnt * 256;
    v = longint'((num + den / 2) / den) + longint'(off);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[vrc_pkg::SITE_W-1:0];
  endfunction

  task automatic apply_word(word_t w);
    logic [vrc_pkg::COLOUR_W-1:0] c;
    centroid_t e;
    c = {w.r, w.g, w.b};
    case (w.act)
      vrc_pkg::ACT_LOAD: begin
        ptable[w.tile] = c;
        ploaded[w.tile] = 1'b1;
        psite_x[w.tile] = w.sx;
        psite_y[w.tile] = w.sy;
      end
      vrc_pkg::ACT_PIXEL: begin
        for (int k = 0; k < NT; k++) begin
          if (ploaded[k] && ptable[k] == c) begin
            if (pcount[k] < longint'(vrc_pkg::DEF_MAX_DIM) * vrc_pkg::DEF_MAX_DIM) begin
              psum_x[k] += w.px; psum_y[k] += w.py; pcount[k] += 1;
            end
            break;
          end
        end
      end
      vrc_pkg::ACT_FINISH: begin
        for (int k = 0; k < NT; k++) begin
          e.idx = k[vrc_pkg::TILE_W-1:0];
          e.lst = (k == NT - 1);
          if (pcount[k] == 0) begin
            e.cx = psite_x[k]; e.cy = psite_y[k]; e.empty = 1'b1;
          end else begin
            e.cx = world_coord(psum_x[k], pscale_x, pcount[k], poff_x);
            e.cy = world_coord(psum_y[k], pscale_y, pcount[k], poff_y);
            e.empty = 1'b0;
          end
          expected_centroids.push_back(e);
          psum_x[k] = 0; psum_y[k] = 0; pcount[k] = 0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver.
  always @(posedge clk) begin
    logic nv;
    if (!rst) begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        apply_word(cur_word);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          action <= cur_word.act; tile_index <= cur_word.tile;
          colour_r <= cur_word.r; colour_g <= cur_word.g; colour_b <= cur_word.b;
          site_x <= cur_word.sx; site_y <= cur_word.sy;
          pixel_x <= cur_word.px; pixel_y <= cur_word.py;
          nv = 1'b1;
          gap_left <= pick_gap();
        end
      end
      in_valid <= nv;
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    centroid_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_centroids.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result: region %0d", region_index);
        end else begin
          e = expected_centroids.pop_front();
          if (region_index !== e.idx || centroid_x !== e.cx || centroid_y !== e.cy ||
              was_empty !== e.empty || last !== e.lst) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected %0d %0d %0d %0b %0b, got %0d %0d %0d %0b %0b",
                       e.idx, e.cx, e.cy, e.empty, e.lst,
                       region_index, centroid_x, centroid_y, was_empty, last);
          end
        end
      end
      if (hold_req && !hold_started && out_valid) begin
        hold_started <= 1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        stall_left <= pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [vrc_pkg::CFG_IDX_W-1:0] idx,
                           logic [vrc_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      vrc_pkg::REG_SCALE_X:  pscale_x = data;
      vrc_pkg::REG_SCALE_Y:  pscale_y = data;
      vrc_pkg::REG_OFFSET_X: poff_x = data[vrc_pkg::SITE_W-1:0];
      vrc_pkg::REG_OFFSET_Y: poff_y = data[vrc_pkg::SITE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [vrc_pkg::SCALE_W-1:0] sx, logic [vrc_pkg::SCALE_W-1:0] sy,
                         logic signed [vrc_pkg::SITE_W-1:0] ox,
                         logic signed [vrc_pkg::SITE_W-1:0] oy);
    cfg_write(vrc_pkg::REG_SCALE_X, sx);
    cfg_write(vrc_pkg::REG_SCALE_Y, sy);
    cfg_write(vrc_pkg::REG_OFFSET_X, vrc_pkg::CFG_DATA_W'(ox));
    cfg_write(vrc_pkg::REG_OFFSET_Y, vrc_pkg::CFG_DATA_W'(oy));
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_centroids.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic word_t mk(logic [vrc_pkg::ACT_W-1:0] a, logic [vrc_pkg::TILE_W-1:0] t,
      logic [vrc_pkg::COLOUR_W-1:0] c, logic signed [vrc_pkg::SITE_W-1:0] sx,
      logic signed [vrc_pkg::SITE_W-1:0] sy,
      logic [vrc_pkg::PIX_W-1:0] px, logic [vrc_pkg::PIX_W-1:0] py);
    word_t w;
    w.act = a; w.tile = t; {w.r, w.g, w.b} = c;
    w.sx = sx; w.sy = sy; w.px = px; w.py = py;
    return w;
  endfunction

  function automatic word_t rand_word(logic [vrc_pkg::ACT_W-1:0] a, bit from_palette);
    word_t w;
    w = mk(a, vrc_pkg::TILE_W'($urandom_range(0, NT - 1)), vrc_pkg::COLOUR_W'($urandom()),
           vrc_pkg::SITE_W'($urandom()), vrc_pkg::SITE_W'($urandom()),
           vrc_pkg::PIX_W'($urandom()), vrc_pkg::PIX_W'($urandom()));
    if (from_palette) {w.r, w.g, w.b} = palette[3'($urandom_range(0, 7))];
    return w;
  endfunction

  task automatic random_phase(int n, bit mid_finish);
    int r;
    for (int k = 0; k < 8; k++) palette[k] = vrc_pkg::COLOUR_W'($urandom());
    for (int k = 0; k < 6; k++) pending_words.push_back(rand_word(vrc_pkg::ACT_LOAD, 1));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (mid_finish && k == n / 2)
        pending_words.push_back(rand_word(vrc_pkg::ACT_FINISH, 0));
      else if (r < 75) pending_words.push_back(rand_word(vrc_pkg::ACT_PIXEL, 1));
      else if (r < 85)
        pending_words.push_back(rand_word(vrc_pkg::ACT_LOAD, $urandom_range(0, 1) == 1));
      else if (r < 95) pending_words.push_back(rand_word(vrc_pkg::ACT_PIXEL, 0));
      else pending_words.push_back(rand_word(ACT_UNUSED, 0));
    end
    pending_words.push_back(rand_word(vrc_pkg::ACT_FINISH, 0));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes, duplicate colours, unmatched and unused action.
    pending_words.push_back(mk(vrc_pkg::ACT_FINISH, 6'd0, 24'd0, 18'sd0, 18'sd0, 10'd0, 10'd0));
    pending_words.push_back(mk(vrc_pkg::ACT_LOAD, 6'd0, 24'h000000,
                               vrc_pkg::Q_MAX, vrc_pkg::Q_MIN, 10'd0, 10'd0));
    pending_words.push_back(mk(vrc_pkg::ACT_LOAD, 6'(NT - 1), 24'hFFFFFF,
                               vrc_pkg::Q_MIN, vrc_pkg::Q_MAX, 10'd0, 10'd0));
    pending_words.push_back(mk(vrc_pkg::ACT_LOAD, 6'd5, 24'h000000,
                               18'sd100, 18'sd200, 10'd0, 10'd0));
    pending_words.push_back(mk(vrc_pkg::ACT_LOAD, 6'd7, 24'h5AA5C3,
                               -18'sd1, 18'sd1, 10'd0, 10'd0));
    pending_words.push_back(mk(vrc_pkg::ACT_PIXEL, 6'd0, 24'h000000,
                               18'sd0, 18'sd0, 10'd1023, 10'd1023));
    pending_words.push_back(mk(vrc_pkg::ACT_PIXEL, 6'd0, 24'h000000,
                               18'sd0, 18'sd0, 10'd0, 10'd0));
    pending_words.push_back(mk(vrc_pkg::ACT_PIXEL, 6'd0, 24'hFFFFFF,
                               18'sd0, 18'sd0, 10'd1023, 10'd0));
    pending_words.push_back(mk(vrc_pkg::ACT_PIXEL, 6'd0, 24'hFFFFFF,
                               18'sd0, 18'sd0, 10'd0, 10'd1023));
    pending_words.push_back(mk(vrc_pkg::ACT_PIXEL, 6'd0, 24'hFFFFFF,
                               18'sd0, 18'sd0, 10'd1, 10'd1));
    pending_words.push_back(mk(vrc_pkg::ACT_PIXEL, 6'd0, 24'h5AA5C3,
                               18'sd0, 18'sd0, 10'd513, 10'd2));
    pending_words.push_back(mk(vrc_pkg::ACT_PIXEL, 6'd0, 24'h123456,
                               18'sd0, 18'sd0, 10'd5, 10'd5));
    pending_words.push_back(mk(ACT_UNUSED, 6'd3, 24'h000000, 18'sd9, 18'sd9, 10'd9, 10'd9));
    pending_words.push_back(mk(vrc_pkg::ACT_FINISH, 6'd0, 24'd0, 18'sd0, 18'sd0, 10'd0, 10'd0));
    wait_idle();
    set_all(24'hFFFFFF, 24'hFFFFFF, vrc_pkg::Q_MAX, vrc_pkg::Q_MAX);
    pending_words.push_back(mk(vrc_pkg::ACT_PIXEL, 6'd0, 24'hFFFFFF,
                               18'sd0, 18'sd0, 10'd1023, 10'd1023));
    pending_words.push_back(mk(vrc_pkg::ACT_PIXEL, 6'd0, 24'h000000,
                               18'sd0, 18'sd0, 10'd0, 10'd0));
    pending_words.push_back(mk(vrc_pkg::ACT_FINISH, 6'd0, 24'd0, 18'sd0, 18'sd0, 10'd0, 10'd0));
    wait_idle();
    set_all(24'h000000, 24'h000000, vrc_pkg::Q_MIN, vrc_pkg::Q_MIN);
    pending_words.push_back(mk(vrc_pkg::ACT_PIXEL, 6'd0, 24'hFFFFFF,
                               18'sd0, 18'sd0, 10'd1023, 10'd1023));
    pending_words.push_back(mk(vrc_pkg::ACT_FINISH, 6'd0, 24'd0, 18'sd0, 18'sd0, 10'd0, 10'd0));
    wait_idle();
    // Random phases.
    set_all(vrc_pkg::SCALE_W'($urandom()), vrc_pkg::SCALE_W'($urandom()),
            vrc_pkg::SITE_W'($urandom()), vrc_pkg::SITE_W'($urandom()));
    random_phase(32, 0);
    wait_idle();
    hold_req = 1;
    no_gaps = 1;
    random_phase(36, 1);
    wait_idle();
    no_gaps = 0;
    set_all(vrc_pkg::SCALE_W'($urandom_range(0, 65535)), vrc_pkg::SCALE_W'($urandom()),
            vrc_pkg::SITE_W'($urandom()), vrc_pkg::SITE_W'($urandom()));
    random_phase(32, 0);
    wait_idle();
    set_all(vrc_pkg::SCALE_RESET, vrc_pkg::SCALE_RESET, 18'sd0, 18'sd0);
    random_phase(32, 1);
    wait_idle();
    if (errors == 0 && expected_centroids.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/vrc_pkg.sv
sv/vrc_div.sv
sv/voronoi_region_centroid.sv
tb/sv/voronoi_region_centroid_tb.sv
